>>> rtl/core/signed_integer_to_radix_text_assert.svh
// assertion helpers, sampled on the rising edge of clk and held off while rst is high
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH

// same-cycle implication
`define SIRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SIRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/sirt_pkg.sv
package sirt_pkg;

  localparam int MAX_RADIX   = 32;
  localparam int ALPHA_SLOTS = 32;
  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = $clog2(ALPHA_SLOTS);
  localparam int MAG_W       = 33;
  localparam int MAX_DIGITS  = 32;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int DIV_STEPS   = MAG_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // register indexes on the configuration port
  localparam logic [2:0] REG_RADIX_LEN = 3'd0;
  localparam logic [2:0] REG_ALPHA_A   = 3'd1;
  localparam logic [2:0] REG_ALPHA_B   = 3'd2;
  localparam logic [2:0] REG_ALPHA_C   = 3'd3;
  localparam logic [2:0] REG_ALPHA_D   = 3'd4;

  typedef logic [ALPHA_SLOTS-1:0][CHAR_W-1:0] alpha_t;

  typedef struct packed {
    logic               done;
    logic               ok;
    logic [RADIX_W-1:0] radix;
  } chk_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/core/sirt_divider.sv
module sirt_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [sirt_pkg::MAG_W-1:0]      dividend,
  input  logic [sirt_pkg::RADIX_W-1:0]    divisor,
  output sirt_pkg::div_status_t           status,
  output logic [sirt_pkg::MAG_W-1:0]      quotient,
  output logic [sirt_pkg::RADIX_W-1:0]    remainder
);

  logic                           busy;
  logic                           done;
  logic [sirt_pkg::STEP_W-1:0]    step;
  logic [sirt_pkg::MAG_W-1:0]     work;
  logic [sirt_pkg::MAG_W-1:0]     work_next;
  logic [sirt_pkg::RADIX_W-1:0]   rem;
  logic [sirt_pkg::RADIX_W-1:0]   rem_next;
  logic [sirt_pkg::RADIX_W-1:0]   dvsr;
  logic [sirt_pkg::RADIX_W:0]     shifted;
  logic [sirt_pkg::RADIX_W:0]     diff;
  logic                           fits;
  logic                           last_step;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    shifted   = {rem, work[sirt_pkg::MAG_W-1]};
    diff      = shifted - {1'b0, dvsr};
    fits      = shifted >= {1'b0, dvsr};
    rem_next  = fits ? diff[sirt_pkg::RADIX_W-1:0] : shifted[sirt_pkg::RADIX_W-1:0];
    work_next = {work[sirt_pkg::MAG_W-2:0], fits};
    last_step = step == sirt_pkg::STEP_W'(sirt_pkg::DIV_STEPS - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = work;
  assign remainder   = rem;

endmodule

>>> rtl/core/sirt_alpha_check.sv
module sirt_alpha_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  sirt_pkg::alpha_t              alpha,
  input  logic [sirt_pkg::RADIX_W-1:0]  radix_length,
  output sirt_pkg::chk_res_t            result
);

  logic                          busy;
  logic [sirt_pkg::RADIX_W-1:0]  idx;
  logic [sirt_pkg::RADIX_W-1:0]  lim;
  logic [sirt_pkg::CHAR_W-1:0]   cur;
  logic                          dup;
  logic                          at_end;
  logic                          bad;

  // walks the alphabet one character a cycle, comparing it with all earlier ones
  always_comb begin
    lim = (radix_length > sirt_pkg::RADIX_W'(sirt_pkg::MAX_RADIX))
        ? sirt_pkg::RADIX_W'(sirt_pkg::MAX_RADIX) : radix_length;
    cur = alpha[idx[sirt_pkg::DIGIT_W-1:0]];
    dup = 1'b0;
    for (int j = 0; j < sirt_pkg::ALPHA_SLOTS; j++) begin
      dup = dup | ((sirt_pkg::RADIX_W'(j) < idx) && (alpha[j] == cur));
    end
    // a zero character ends the alphabet like a string terminator
    at_end = (idx == lim) || (cur == '0);
    bad    = (cur == sirt_pkg::CHAR_PLUS) || (cur == sirt_pkg::CHAR_MINUS) || dup;
    result.done  = busy && (at_end || bad);
    result.ok    = at_end && (idx >= sirt_pkg::RADIX_W'(2));
    result.radix = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy) begin
      if (at_end || bad) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/signed_integer_to_radix_text.sv
// an input beat starts an alphabet check (one character a cycle), then one 33-step
// restoring division per digit; a new number is taken only in idle, after the last
// character of the previous one has been loaded into the output register
// characters leave at one per cycle while the sink is ready
// reset: synchronous active-high rst clears the sequencer, output valid and all
// configuration registers, leaving the alphabet empty and invalid
module signed_integer_to_radix_text (
  input  logic               clk,
  input  logic               rst,
  // stream in
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic signed [31:0] s_tdata,   // [31:0] number_value
  // stream out
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // [7:0] text_char
  output logic               m_tlast,   // last_char
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  `include "signed_integer_to_radix_text_assert.svh"

  sirt_pkg::state_t                  state;
  sirt_pkg::state_t                  state_next;
  logic [sirt_pkg::RADIX_W-1:0]      radix_length;
  logic [63:0]                       alpha_a;
  logic [63:0]                       alpha_b;
  logic [63:0]                       alpha_c;
  logic [63:0]                       alpha_d;
  sirt_pkg::alpha_t                  alpha;
  logic                              cfg_wr;

  logic                              neg;
  logic [sirt_pkg::MAG_W-1:0]        mag;
  logic [sirt_pkg::RADIX_W-1:0]      radix;
  logic [sirt_pkg::CNT_W-1:0]        nd;
  logic [sirt_pkg::CNT_W-1:0]        cnt;
  logic [sirt_pkg::CNT_W-1:0]        cnt_m1;
  logic [sirt_pkg::CHAR_W-1:0]       digits [sirt_pkg::MAX_DIGITS];

  logic                              chk_start;
  sirt_pkg::chk_res_t                chk_res;
  logic                              div_start;
  logic [sirt_pkg::MAG_W-1:0]        div_dividend;
  logic [sirt_pkg::RADIX_W-1:0]      div_divisor;
  sirt_pkg::div_status_t             div_st;
  logic [sirt_pkg::MAG_W-1:0]        div_quot;
  logic [sirt_pkg::RADIX_W-1:0]      div_rem;
  logic                              more;
  logic                              load_ok;
  logic                              load_sign;
  logic                              load_digit;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign alpha  = {alpha_d, alpha_c, alpha_b, alpha_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_length <= '0;
      alpha_a      <= '0;
      alpha_b      <= '0;
      alpha_c      <= '0;
      alpha_d      <= '0;
    end else if (cfg_wr) begin
      case (paddr[5:3])
        sirt_pkg::REG_RADIX_LEN: radix_length <= pwdata[sirt_pkg::RADIX_W-1:0];
        sirt_pkg::REG_ALPHA_A:   alpha_a      <= pwdata;
        sirt_pkg::REG_ALPHA_B:   alpha_b      <= pwdata;
        sirt_pkg::REG_ALPHA_C:   alpha_c      <= pwdata;
        sirt_pkg::REG_ALPHA_D:   alpha_d      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      sirt_pkg::REG_RADIX_LEN: prdata = {{(64 - sirt_pkg::RADIX_W){1'b0}}, radix_length};
      sirt_pkg::REG_ALPHA_A:   prdata = alpha_a;
      sirt_pkg::REG_ALPHA_B:   prdata = alpha_b;
      sirt_pkg::REG_ALPHA_C:   prdata = alpha_c;
      sirt_pkg::REG_ALPHA_D:   prdata = alpha_d;
      default:                 prdata = '0;
    endcase
  end

  sirt_alpha_check u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (chk_start),
    .alpha        (alpha),
    .radix_length (radix_length),
    .result       (chk_res)
  );

  sirt_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .status    (div_st),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign cnt_m1  = cnt - 1'b1;
  assign load_ok = !m_tvalid || m_tready;
  // keep dividing while the quotient is nonzero and the digit buffer has room
  assign more    = (div_quot != '0) && (nd < sirt_pkg::CNT_W'(sirt_pkg::MAX_DIGITS - 1));

  always_comb begin
    state_next = state;
    case (state)
      sirt_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = sirt_pkg::ST_CHECK;
      end
      sirt_pkg::ST_CHECK: begin
        if (chk_res.done) state_next = chk_res.ok ? sirt_pkg::ST_DIVIDE : sirt_pkg::ST_IDLE;
      end
      sirt_pkg::ST_DIVIDE: begin
        if (div_st.done && !more) state_next = neg ? sirt_pkg::ST_SIGN : sirt_pkg::ST_EMIT;
      end
      sirt_pkg::ST_SIGN: begin
        if (load_ok) state_next = sirt_pkg::ST_EMIT;
      end
      sirt_pkg::ST_EMIT: begin
        if (load_ok && (cnt == sirt_pkg::CNT_W'(1))) state_next = sirt_pkg::ST_IDLE;
      end
      default: state_next = sirt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    chk_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quot;
    div_divisor  = radix;
    load_sign    = 1'b0;
    load_digit   = 1'b0;
    case (state)
      sirt_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        chk_start = s_tvalid;
      end
      sirt_pkg::ST_CHECK: begin
        div_start    = chk_res.done && chk_res.ok;
        div_dividend = mag;
        div_divisor  = chk_res.radix;
      end
      sirt_pkg::ST_DIVIDE: begin
        div_start = div_st.done && more;
      end
      sirt_pkg::ST_SIGN: begin
        load_sign = load_ok;
      end
      sirt_pkg::ST_EMIT: begin
        load_digit = load_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sirt_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      nd       <= '0;
      cnt      <= '0;
    end else begin
      state <= state_next;
      if (state == sirt_pkg::ST_CHECK && chk_res.done) begin
        nd <= '0;
      end
      if (state == sirt_pkg::ST_DIVIDE && div_st.done) begin
        nd  <= nd + 1'b1;
        cnt <= nd + 1'b1;
      end else if (load_digit) begin
        cnt <= cnt_m1;
      end
      if (load_sign || load_digit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      neg <= s_tdata[31];
      // 33-bit magnitude so the most negative value comes out right
      mag <= s_tdata[31] ? ({1'b0, ~s_tdata} + sirt_pkg::MAG_W'(1)) : {1'b0, s_tdata};
    end
    if (state == sirt_pkg::ST_CHECK && chk_res.done) begin
      radix <= chk_res.radix;
    end
    if (state == sirt_pkg::ST_DIVIDE && div_st.done) begin
      digits[nd[sirt_pkg::DIGIT_W-1:0]] <= alpha[div_rem[sirt_pkg::DIGIT_W-1:0]];
    end
    if (load_sign) begin
      m_tdata <= sirt_pkg::CHAR_MINUS;
      m_tlast <= 1'b0;
    end else if (load_digit) begin
      m_tdata <= digits[cnt_m1[sirt_pkg::DIGIT_W-1:0]];
      m_tlast <= cnt == sirt_pkg::CNT_W'(1);
    end
  end

  `SIRT_ASSERT_NOW(a_div_start_idle, div_start, !div_st.busy, "divider restarted while busy")
  `SIRT_ASSERT_NOW(a_chk_radix, chk_res.done && chk_res.ok, (chk_res.radix >= sirt_pkg::RADIX_W'(2)) && (chk_res.radix <= sirt_pkg::RADIX_W'(sirt_pkg::MAX_RADIX)), "accepted radix out of range")
  `SIRT_ASSERT_NOW(a_rem_range, div_st.done && (state == sirt_pkg::ST_DIVIDE), div_rem < radix, "remainder not below radix")
  `SIRT_ASSERT_NEXT(a_accept_check, s_tvalid && s_tready, state == sirt_pkg::ST_CHECK, "accepted beat did not start alphabet check")
  `SIRT_ASSERT_NOW(a_emit_count, state == sirt_pkg::ST_EMIT, (cnt != '0) && (cnt <= nd), "digit count out of step while emitting")

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int DRAIN_CYCLES = 1200;   // idle wait before the alphabet is reprogrammed and at the end of the run
  localparam int STALL_LIMIT  = 20000;

  typedef logic [3:0][63:0] alpha_regs_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // shadow of the configuration registers
  logic [5:0]  radix_len_sh = '0;
  logic [63:0] alpha_sh [4] = '{default: '0};

  text_beat_t  pending_chars[$];
  text_beat_t  want;
  int          error_count = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          quiet_cycles = 0;

  signed_integer_to_radix_text dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  function automatic logic [7:0] alpha_char(input int k);
    return alpha_sh[k / 8][8 * (k % 8) +: 8];
  endfunction

  // effective radix of the shadow alphabet, 0 when invalid
  function automatic int digit_radix();
    int lim;
    int n;
    logic [7:0] c;
    lim = (radix_len_sh > sirt_pkg::MAX_RADIX) ? sirt_pkg::MAX_RADIX : radix_len_sh;
    n = 0;
    while (n < lim && alpha_char(n) != 8'h00) n++;
    if (n < 2) return 0;
    for (int i = 0; i < n; i++) begin
      c = alpha_char(i);
      if (c == sirt_pkg::CHAR_PLUS || c == sirt_pkg::CHAR_MINUS) return 0;
      for (int j = i + 1; j < n; j++)
        if (alpha_char(j) == c) return 0;
    end
    return n;
  endfunction

  task automatic render_number(input logic [31:0] v);
    int radix;
    int nd;
    longint mag;
    logic [7:0] digits [33];
    text_beat_t b;
    radix = digit_radix();
    if (radix == 0) return;
    mag = longint'($signed(v));
    if (mag < 0) mag = -mag;
    nd = 0;
    do begin
      digits[nd] = alpha_char(int'(mag % radix));
      nd++;
      mag = mag / radix;
    end while (mag != 0 && nd < 32);
    if (v[31]) begin
      b.ch = sirt_pkg::CHAR_MINUS;
      b.last = 1'b0;
      pending_chars.push_back(b);
    end
    for (int k = nd; k > 0; k--) begin
      b.ch = digits[k - 1];
      b.last = (k == 1);
      pending_chars.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected beat: text_char expected none, actual %h", m_tdata);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (m_tdata !== want.ch) begin
          $error("text_char: expected %h, actual %h", want.ch, m_tdata);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last_char: expected %b, actual %b", want.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send_number(input logic [31:0] v);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    render_number(v);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // psel stays high between back-to-back writes; caller lowers psel afterwards
  task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      sirt_pkg::REG_RADIX_LEN: radix_len_sh = val[5:0];
      sirt_pkg::REG_ALPHA_A:   alpha_sh[0] = val;
      sirt_pkg::REG_ALPHA_B:   alpha_sh[1] = val;
      sirt_pkg::REG_ALPHA_C:   alpha_sh[2] = val;
      sirt_pkg::REG_ALPHA_D:   alpha_sh[3] = val;
      default: ;
    endcase
  endtask

  task automatic program_alphabet(input logic [5:0] len, input alpha_regs_t chars);
    stop_sending();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    apb_write(sirt_pkg::REG_RADIX_LEN, {$urandom, $urandom} & ~64'h3F | 64'(len));
    apb_write(sirt_pkg::REG_ALPHA_A, chars[0]);
    apb_write(sirt_pkg::REG_ALPHA_B, chars[1]);
    apb_write(sirt_pkg::REG_ALPHA_C, chars[2]);
    apb_write(sirt_pkg::REG_ALPHA_D, chars[3]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic alpha_regs_t pack_text(input string s);
    alpha_regs_t r;
    r = '0;
    for (int k = 0; k < s.len() && k < 32; k++)
      r[k / 8][8 * (k % 8) +: 8] = s[k];
    return r;
  endfunction

  task automatic test_reset_alphabet();
    send_number(32'd0);
    send_number(32'hFFFF_FFFB);
  endtask

  task automatic test_decimal();
    program_alphabet(6'd10, pack_text("0123456789"));
    send_number(32'd0);
    send_number(32'd7);
    send_number(32'hFFFF_FFFF);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'd1000);
  endtask

  task automatic test_binary();
    program_alphabet(6'd2, pack_text("01"));
    send_number(32'h8000_0000);
    send_number(32'hFFFF_FFFF);
    send_number(32'h7FFF_FFFF);
  endtask

  // length register above the limit saturates to the full 32 characters
  task automatic test_full_alphabet();
    program_alphabet(6'd63, pack_text("0123456789ABCDEFGHIJKLMNOPQRSTUV"));
    send_number(32'd0);
    send_number(32'h8000_0000);
    send_number(32'd31);
    send_number(32'd32);
  endtask

  task automatic test_bad_alphabets();
    alpha_regs_t a;
    // terminator cuts the alphabet to five characters
    a = pack_text("01234");
    a[0][8 * 6 +: 8] = "9";
    program_alphabet(6'd16, a);
    send_number(32'hFFFF_FF85);
    program_alphabet(6'd1, pack_text("01"));
    send_number(32'd5);
    program_alphabet(6'd4, pack_text("0+12"));
    send_number(32'd5);
    program_alphabet(6'd4, pack_text("01-3"));
    send_number(32'd5);
    program_alphabet(6'd4, pack_text("0120"));
    send_number(32'd5);
    program_alphabet(6'd0, pack_text("0123"));
    send_number(32'd5);
  endtask

  task automatic random_alphabet();
    alpha_regs_t a;
    logic [255:0] used;
    logic [7:0] c;
    logic [5:0] len;
    int n;
    int i;
    int j;
    a = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    used = '0;
    n = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(2, 32);
    for (int k = 0; k < n; k++) begin
      do c = 8'($urandom_range(1, 255));
      while (c == sirt_pkg::CHAR_PLUS || c == sirt_pkg::CHAR_MINUS || used[c]);
      used[c] = 1'b1;
      a[k / 8][8 * (k % 8) +: 8] = c;
    end
    len = (n == 32) ? 6'($urandom_range(32, 63)) : 6'(n);
    case ($urandom_range(0, 9))
      6: a[0][7:0] = 8'h00;
      7: begin
        i = $urandom_range(0, n - 1);
        a[i / 8][8 * (i % 8) +: 8] = 8'h00;
      end
      8: begin
        i = $urandom_range(0, n - 1);
        a[i / 8][8 * (i % 8) +: 8] =
            $urandom_range(0, 1) ? sirt_pkg::CHAR_PLUS : sirt_pkg::CHAR_MINUS;
      end
      9: begin
        j = $urandom_range(1, n - 1);
        i = $urandom_range(0, j - 1);
        a[j / 8][8 * (j % 8) +: 8] = a[i / 8][8 * (i % 8) +: 8];
      end
      default: if ($urandom_range(0, 19) == 0) len = 6'($urandom_range(0, 1));
    endcase
    program_alphabet(len, a);
  endtask

  function automatic logic [31:0] random_number();
    longint p;
    int r;
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 40));
      1: return -32'($urandom_range(0, 40));
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      3: begin
        // around a power of the radix, where the digit count steps
        r = digit_radix();
        if (r < 2) r = 2;
        p = 1;
        repeat ($urandom_range(1, 31)) if (p * r < 64'h8000_0000) p = p * r;
        p = p + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? 32'(p) : -32'(p);
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_phase(input int src_pct, input int snk_pct, input int n_items);
    int sent;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      random_alphabet();
      repeat ($urandom_range(6, 14)) begin
        sent++;
        send_number(random_number());
        if ($urandom_range(0, 19) == 0) begin
          stop_sending();
          wait_drained();
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_alphabet();
    test_decimal();
    test_binary();
    test_full_alphabet();
    test_bad_alphabets();
    test_random_phase(0, 0, 45);
    test_random_phase(84, 0, 45);
    test_random_phase(0, 84, 45);
    test_random_phase(27, 27, 45);
    stop_sending();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
